FILE: rtl/edf_pkg.sv
// Package for the deadline-sorted ready queue: word types, codes and helpers.
`default_nettype none
package edf_pkg;

    localparam int QueueDepthDefault = 16;
    localparam int MsPerSec = 1000;
    localparam int MsWidth = 26;

    typedef enum logic [1:0] {
        CMD_ADD       = 2'd0,
        CMD_SELECT    = 2'd1,
        CMD_PREEMPT   = 2'd2,
        CMD_SET_READY = 2'd3
    } command_t;

    typedef enum logic [3:0] {
        OC_ADDED       = 4'd0,
        OC_FULL        = 4'd1,
        OC_DROPPED     = 4'd2,
        OC_SELECTED    = 4'd3,
        OC_NONE        = 4'd4,
        OC_KEEP        = 4'd5,
        OC_PREEMPT     = 4'd6,
        OC_RUN_EXPIRED = 4'd7,
        OC_FLAG_SET    = 4'd8,
        OC_ID_MISSING  = 4'd9
    } outcome_t;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_INSERT,
        OP_REMOVE,
        OP_SET_READY
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } state_t;

    typedef struct packed {
        command_t    command;
        logic [15:0] task_id;
        logic [31:0] task_deadline;
        logic [15:0] start_sec;
        logic [15:0] end_sec;
        logic        ready_flag;
        logic [31:0] now_ms;
        logic [31:0] running_deadline;
        logic [15:0] running_end_sec;
    } in_word_t;

    typedef struct packed {
        outcome_t    outcome;
        logic [15:0] result_id;
        logic [31:0] result_deadline;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] deadline;
        logic [15:0] start;
        logic [15:0] stop;
        logic        ready;
    } entry_t;

    // Broadcast from the sequencer to every cell
    typedef struct packed {
        cell_op_t    op;
        entry_t      new_ent;
        logic [31:0] now_ms;
        logic [31:0] run_deadline;
    } cell_ctrl_t;

    // First-hit data carried along the chain
    typedef struct packed {
        logic        expired;
        logic [15:0] id;
        logic [31:0] deadline;
    } sel_t;

    // Any-hit flags carried along the chain
    typedef struct packed {
        logic earlier;
        logic id_hit;
    } flags_t;

    function automatic logic [MsWidth-1:0] sec_to_ms(input logic [15:0] s);
        sec_to_ms = MsWidth'(s) * MsWidth'(MsPerSec);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/edf_cell.sv
// One queue slot: holds an entry, shifts it left or right and flags hits.
`default_nettype none
module edf_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  edf_pkg::cell_ctrl_t     ctrl,
    input  edf_pkg::entry_t         left_ent,
    input  wire logic               left_occ,
    input  wire logic               left_after,
    input  edf_pkg::entry_t         right_ent,
    input  wire logic               right_occ,
    input  wire logic               hit_before,
    input  edf_pkg::sel_t           sel_in,
    input  edf_pkg::flags_t         flags_in,
    output edf_pkg::entry_t         ent,
    output logic                    occ,
    output logic                    after,
    output logic                    hit_incl,
    output edf_pkg::sel_t           sel_out,
    output edf_pkg::flags_t         flags_out
);

    edf_pkg::entry_t ent_reg, ent_next;
    logic            occ_reg, occ_next;
    logic            expired, eligible, hit_here, id_match;

    // Evaluate this slot against the current time and keys
    always_comb
    begin
        expired  = occ_reg && ({6'd0, edf_pkg::sec_to_ms(ent_reg.stop)}) < ctrl.now_ms;
        eligible = occ_reg && ent_reg.ready &&
                   ctrl.now_ms >= {6'd0, edf_pkg::sec_to_ms(ent_reg.start)};
        hit_here = expired || eligible;
        id_match = occ_reg && (ent_reg.id == ctrl.new_ent.id);
        after    = occ_reg && (ent_reg.deadline <= ctrl.new_ent.deadline);
        hit_incl = hit_before || hit_here;
        sel_out  = (hit_here && !hit_before) ?
                   edf_pkg::sel_t'{expired: expired, id: ent_reg.id,
                                   deadline: ent_reg.deadline} : sel_in;
        flags_out.earlier = flags_in.earlier ||
                            (eligible && ent_reg.deadline < ctrl.run_deadline);
        flags_out.id_hit  = flags_in.id_hit || id_match;
    end

    // Next slot contents
    always_comb
    begin
        ent_next = ent_reg;
        occ_next = occ_reg;
        case (ctrl.op)
            edf_pkg::OP_INSERT:
            begin
                if (!after)
                begin
                    if (left_after)
                    begin
                        ent_next = ctrl.new_ent;
                        occ_next = 1'b1;
                    end
                    else
                    begin
                        ent_next = left_ent;
                        occ_next = left_occ;
                    end
                end
            end
            edf_pkg::OP_REMOVE:
            begin
                if (hit_incl)
                begin
                    ent_next = right_ent;
                    occ_next = right_occ;
                end
            end
            edf_pkg::OP_SET_READY:
            begin
                if (id_match)
                    ent_next.ready = ctrl.new_ent.ready;
            end
            default:
            begin
            end
        endcase
    end

    // Hold slot state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= 1'b0;
        else
            occ_reg <= occ_next;
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent = ent_reg;
    assign occ = occ_reg;

endmodule
`default_nettype wire

FILE: rtl/edf_ready_queue.sv
// Top level of the earliest-deadline-first ready queue.
// Takes one command word at a time and answers with one result word, except a
// select, which answers with one word per expired entry dropped and then one
// selected or none word (up to QUEUE_DEPTH + 1 words). Each step of the slot chain
// produces one result word, and the chain steps only while the output register is
// free, so results wait whenever the result side stalls. Slots form a sorted shift
// chain: inserts and removals move all later slots by one in the same step.
`default_nettype none
module edf_ready_queue #(
    parameter int QUEUE_DEPTH = edf_pkg::QueueDepthDefault
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cmd_valid,
    output logic              cmd_stall,
    input  edf_pkg::in_word_t cmd_data,
    output logic              res_valid,
    input  wire logic         res_stall,
    output edf_pkg::out_word_t res_data
);

    edf_pkg::state_t     state_reg, state_next;
    edf_pkg::in_word_t   item_reg;
    edf_pkg::out_word_t  out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic                step, done;
    edf_pkg::cell_op_t   op;
    edf_pkg::cell_ctrl_t ctrl;

    edf_pkg::entry_t ent_q   [QUEUE_DEPTH];
    logic            occ_q   [QUEUE_DEPTH];
    logic            after_q [QUEUE_DEPTH];
    logic            hit_q   [QUEUE_DEPTH];
    edf_pkg::sel_t   sel_q   [QUEUE_DEPTH];
    edf_pkg::flags_t flags_q [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] occ_vec;

    // Advance one result whenever the output register is free
    assign step = (state_reg == edf_pkg::ST_BUSY) && (!out_valid_reg || !res_stall);

    always_comb
    begin
        ctrl.op           = step ? op : edf_pkg::OP_NOP;
        ctrl.new_ent      = '{id: item_reg.task_id, deadline: item_reg.task_deadline,
                              start: item_reg.start_sec, stop: item_reg.end_sec,
                              ready: item_reg.ready_flag};
        ctrl.now_ms       = item_reg.now_ms;
        ctrl.run_deadline = item_reg.running_deadline;
    end

    // Slot chain
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        edf_pkg::entry_t l_ent, r_ent;
        logic            l_occ, l_after, r_occ, h_before;
        edf_pkg::sel_t   s_in;
        edf_pkg::flags_t f_in;

        if (i == 0)
        begin : g_head
            assign l_ent    = '0;
            assign l_occ    = 1'b0;
            assign l_after  = 1'b1;
            assign h_before = 1'b0;
            assign s_in     = '0;
            assign f_in     = '0;
        end
        else
        begin : g_body
            assign l_ent    = ent_q[i-1];
            assign l_occ    = occ_q[i-1];
            assign l_after  = after_q[i-1];
            assign h_before = hit_q[i-1];
            assign s_in     = sel_q[i-1];
            assign f_in     = flags_q[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign r_ent = '0;
            assign r_occ = 1'b0;
        end
        else
        begin : g_inner
            assign r_ent = ent_q[i+1];
            assign r_occ = occ_q[i+1];
        end

        edf_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .left_ent   (l_ent),
            .left_occ   (l_occ),
            .left_after (l_after),
            .right_ent  (r_ent),
            .right_occ  (r_occ),
            .hit_before (h_before),
            .sel_in     (s_in),
            .flags_in   (f_in),
            .ent        (ent_q[i]),
            .occ        (occ_q[i]),
            .after      (after_q[i]),
            .hit_incl   (hit_q[i]),
            .sel_out    (sel_q[i]),
            .flags_out  (flags_q[i])
        );

        assign occ_vec[i] = occ_q[i];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            edf_pkg::ST_IDLE:
                if (cmd_valid)
                    state_next = edf_pkg::ST_BUSY;
            edf_pkg::ST_BUSY:
                if (step && done)
                    state_next = edf_pkg::ST_IDLE;
            default:
                state_next = edf_pkg::ST_IDLE;
        endcase
    end

    // Result word and chain operation for this step
    always_comb
    begin
        edf_pkg::sel_t   s;
        edf_pkg::flags_t f;
        s = sel_q[QUEUE_DEPTH-1];
        f = flags_q[QUEUE_DEPTH-1];
        op   = edf_pkg::OP_NOP;
        done = 1'b1;
        out_next = '{outcome: edf_pkg::OC_NONE, result_id: 16'd0,
                     result_deadline: 32'd0, last: 1'b1};
        case (item_reg.command)
            edf_pkg::CMD_ADD:
            begin
                if (occ_q[QUEUE_DEPTH-1])
                    out_next.outcome = edf_pkg::OC_FULL;
                else
                begin
                    out_next.outcome = edf_pkg::OC_ADDED;
                    op = edf_pkg::OP_INSERT;
                end
            end
            edf_pkg::CMD_SELECT:
            begin
                if (hit_q[QUEUE_DEPTH-1])
                begin
                    op = edf_pkg::OP_REMOVE;
                    out_next.result_id = s.id;
                    if (s.expired)
                    begin
                        out_next.outcome = edf_pkg::OC_DROPPED;
                        out_next.last    = 1'b0;
                        done             = 1'b0;
                    end
                    else
                    begin
                        out_next.outcome         = edf_pkg::OC_SELECTED;
                        out_next.result_deadline = s.deadline;
                    end
                end
            end
            edf_pkg::CMD_PREEMPT:
            begin
                if (item_reg.now_ms >
                    {6'd0, edf_pkg::sec_to_ms(item_reg.running_end_sec)})
                    out_next.outcome = edf_pkg::OC_RUN_EXPIRED;
                else if (f.earlier)
                    out_next.outcome = edf_pkg::OC_PREEMPT;
                else
                    out_next.outcome = edf_pkg::OC_KEEP;
            end
            edf_pkg::CMD_SET_READY:
            begin
                op = edf_pkg::OP_SET_READY;
                out_next.outcome = f.id_hit ? edf_pkg::OC_FLAG_SET : edf_pkg::OC_ID_MISSING;
            end
            default:
            begin
            end
        endcase
    end

    // Drop the output word once taken, load a new one on each step
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !res_stall)
            out_valid_next = 1'b0;
        if (step)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= edf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == edf_pkg::ST_IDLE && cmd_valid)
            item_reg <= cmd_data;
        if (step)
            out_reg <= out_next;
    end

    assign cmd_stall = (state_reg != edf_pkg::ST_IDLE);
    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    // Occupied slots always form a prefix of the chain
    a_occ_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((occ_vec & (occ_vec + QUEUE_DEPTH'(1))) == '0))
        else $error("slot occupancy is not a prefix");

    // An add to a full queue leaves the chain unchanged
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item_reg.command == edf_pkg::CMD_ADD && occ_q[QUEUE_DEPTH-1])
        |=> $stable(occ_vec))
        else $error("add to full queue changed occupancy");

    // A new result word appears only after a step of a busy sequencer
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == edf_pkg::ST_BUSY))
        else $error("result word without a command in progress");

endmodule
`default_nettype wire

FILE: dv/tb_edf_ready_queue.sv
// Testbench for the deadline-sorted ready queue: random and directed commands checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_edf_ready_queue;

    localparam int Depth = edf_pkg::QueueDepthDefault;
    localparam int WatchdogLimit = 20000;

    // Predicted queue contents and the expected words they produce
    class edf_scoreboard;
        edf_pkg::entry_t    slots[$];
        edf_pkg::out_word_t expected_words[$];
        int                 mismatches;

        function void push_word(edf_pkg::outcome_t oc, logic [15:0] id, logic [31:0] dl);
            edf_pkg::out_word_t w;
            w.outcome = oc;
            w.result_id = id;
            w.result_deadline = dl;
            w.last = 1'b0;
            expected_words.push_back(w);
        endfunction

        // Note an accepted command and predict its result words
        function void note_command(edf_pkg::in_word_t c);
            edf_pkg::entry_t e;
            int pos;
            int i;
            logic [63:0] now;
            bit found;
            bit hit;
            now = {32'd0, c.now_ms};
            found = 0;
            hit = 0;
            case (c.command)
                edf_pkg::CMD_ADD:
                begin
                    if (slots.size() >= Depth)
                    begin
                        push_word(edf_pkg::OC_FULL, '0, '0);
                    end
                    else
                    begin
                        e.id = c.task_id;
                        e.deadline = c.task_deadline;
                        e.start = c.start_sec;
                        e.stop = c.end_sec;
                        e.ready = c.ready_flag;
                        pos = 0;
                        while (pos < slots.size() && slots[pos].deadline <= c.task_deadline)
                            pos++;
                        slots.insert(pos, e);
                        push_word(edf_pkg::OC_ADDED, '0, '0);
                    end
                end
                edf_pkg::CMD_SELECT:
                begin
                    i = 0;
                    while (i < slots.size() && !found)
                    begin
                        if (now > 64'(slots[i].stop) * 1000)
                        begin
                            push_word(edf_pkg::OC_DROPPED, slots[i].id, '0);
                            slots.delete(i);
                        end
                        else if (slots[i].ready && now >= 64'(slots[i].start) * 1000)
                        begin
                            push_word(edf_pkg::OC_SELECTED, slots[i].id, slots[i].deadline);
                            slots.delete(i);
                            found = 1;
                        end
                        else
                            i++;
                    end
                    if (!found)
                        push_word(edf_pkg::OC_NONE, '0, '0);
                end
                edf_pkg::CMD_PREEMPT:
                begin
                    if (now > 64'(c.running_end_sec) * 1000)
                        push_word(edf_pkg::OC_RUN_EXPIRED, '0, '0);
                    else
                    begin
                        foreach (slots[k])
                            if (slots[k].ready && now >= 64'(slots[k].start) * 1000 &&
                                slots[k].deadline < c.running_deadline)
                                hit = 1;
                        push_word(hit ? edf_pkg::OC_PREEMPT : edf_pkg::OC_KEEP, '0, '0);
                    end
                end
                default:
                begin
                    foreach (slots[k])
                        if (slots[k].id == c.task_id)
                        begin
                            slots[k].ready = c.ready_flag;
                            hit = 1;
                        end
                    push_word(hit ? edf_pkg::OC_FLAG_SET : edf_pkg::OC_ID_MISSING, '0, '0);
                end
            endcase
            expected_words[$].last = 1'b1;
        endfunction

        // Compare one result word against the oldest expectation
        function void check_word(edf_pkg::out_word_t got);
            edf_pkg::out_word_t exp_w;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %p", got);
                return;
            end
            exp_w = expected_words.pop_front();
            if (got.outcome !== exp_w.outcome || got.result_id !== exp_w.result_id ||
                got.result_deadline !== exp_w.result_deadline || got.last !== exp_w.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, got %p", exp_w, got);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cmd_valid;
    logic               cmd_stall;
    edf_pkg::in_word_t  cmd_data;
    logic               res_valid;
    logic               res_stall;
    edf_pkg::out_word_t res_data;

    edf_scoreboard     board;
    edf_pkg::in_word_t directed_cmds[$];
    bit                stim_done;
    int                idle_cycles;
    int                stall_left;

    edf_ready_queue i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic edf_pkg::in_word_t random_cmd();
        edf_pkg::in_word_t c;
        c = '0;
        c.command = edf_pkg::command_t'($urandom_range(0, 3));
        c.task_id = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
        c.task_deadline = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 40);
        c.start_sec = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
        c.end_sec = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(5, 60));
        c.ready_flag = $urandom_range(0, 3) != 0;
        c.now_ms = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 60000);
        c.running_deadline = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 40);
        c.running_end_sec = ($urandom_range(0, 7) == 0) ? 16'($urandom) :
                            16'($urandom_range(0, 60));
        // Bias toward adds so the queue fills and selects have work to do
        if ($urandom_range(0, 9) < 3)
            c.command = edf_pkg::CMD_ADD;
        return c;
    endfunction

    function automatic edf_pkg::in_word_t make_cmd(edf_pkg::command_t op, logic [15:0] id,
                                                   logic [31:0] dl, logic [15:0] st,
                                                   logic [15:0] en, logic rdy,
                                                   logic [31:0] now, logic [31:0] rdl,
                                                   logic [15:0] ren);
        edf_pkg::in_word_t c;
        c.command = op;
        c.task_id = id;
        c.task_deadline = dl;
        c.start_sec = st;
        c.end_sec = en;
        c.ready_flag = rdy;
        c.now_ms = now;
        c.running_deadline = rdl;
        c.running_end_sec = ren;
        return c;
    endfunction

    // Send one command word after a random gap
    task automatic send_cmd(edf_pkg::in_word_t c);
        int gap;
        gap = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        board.note_command(c);
    endtask

    // Result side: sample accepted words and draw stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
                board.check_word(res_data);
            if (res_valid && !res_stall || stall_left == 0)
            begin
                stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
                res_stall <= (stall_left != 0);
            end
            else
            begin
                stall_left--;
                res_stall <= (stall_left != 0);
            end
        end
    end

    // Count cycles with no accepted word on either side
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("tb_edf_ready_queue: FAIL");
            $finish;
        end
    end

    initial
    begin
        int n;
        board = new();
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd_data = '0;
        res_stall = 1'b0;
        stall_left = 0;
        idle_cycles = 0;
        stim_done = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty queue, extremes, ties, full queue, duplicates, drops
        directed_cmds.push_back(make_cmd(edf_pkg::CMD_SELECT, '0, '0, '0, '0, 1'b0,
                                         '0, '0, '0));
        directed_cmds.push_back(make_cmd(edf_pkg::CMD_SET_READY, 16'hffff, '0, '0, '0, 1'b1,
                                         '0, '0, '0));
        directed_cmds.push_back(make_cmd(edf_pkg::CMD_PREEMPT, '0, '0, '0, '0, 1'b0,
                                         32'hffffffff, '0, 16'hffff));
        directed_cmds.push_back(make_cmd(edf_pkg::CMD_PREEMPT, '0, '0, '0, '0, 1'b0,
                                         '0, 32'hffffffff, '0));
        for (int k = 0; k < 17; k++)
            directed_cmds.push_back(make_cmd(edf_pkg::CMD_ADD, 16'(k % 3),
                                             (k < 8) ? 32'd7 : 32'hffffffff,
                                             (k == 0) ? 16'hffff : 16'd0,
                                             (k == 1) ? 16'hffff : 16'(k), 1'(k % 2),
                                             '0, '0, '0));
        directed_cmds.push_back(make_cmd(edf_pkg::CMD_SET_READY, 16'd1, '0, '0, '0, 1'b1,
                                         '0, '0, '0));
        directed_cmds.push_back(make_cmd(edf_pkg::CMD_PREEMPT, '0, '0, '0, '0, 1'b0,
                                         32'd3000, 32'd8, 16'd5));
        directed_cmds.push_back(make_cmd(edf_pkg::CMD_SELECT, '0, '0, '0, '0, 1'b0,
                                         32'd9001, '0, '0));
        directed_cmds.push_back(make_cmd(edf_pkg::CMD_SELECT, '0, '0, '0, '0, 1'b0,
                                         32'hffffffff, '0, '0));
        foreach (directed_cmds[k])
            send_cmd(directed_cmds[k]);

        for (n = 0; n < 445; n++)
            send_cmd(random_cmd());
        cmd_valid <= 1'b0;

        // Drain, then allow the pipeline to settle
        while (board.expected_words.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (board.mismatches == 0 && board.expected_words.size() == 0)
            $display("tb_edf_ready_queue: PASS");
        else
            $display("tb_edf_ready_queue: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
